### hdl/source_tokenizer_top_defines.svh
// Assertion macros shared by the tokenizer checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef SOURCE_TOKENIZER_TOP_DEFINES_SVH
`define SOURCE_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define STOK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define STOK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/stok_pkg.sv
// Types, character codes, token kinds and classifier functions for the tokenizer.
// Depends on nothing; used by source_tokenizer_top and stok_checker.
package stok_pkg;

   localparam int INDEX_BITS = 16;
   localparam int FIELD_BITS = 16;
   localparam int KIND_BITS  = 6;
   localparam int FIFO_DEPTH = 8;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS   = PTR_BITS + 1;
   localparam int MAX_TOKENS = 3;

   localparam logic [FIELD_BITS-1:0] LINE_MAX = '1;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SLASH   = "/";
   localparam logic [7:0] CHAR_STAR    = "*";
   localparam logic [7:0] CHAR_DOT     = ".";
   localparam logic [7:0] CHAR_EQUAL   = "=";
   localparam logic [7:0] CHAR_GREATER = ">";
   localparam logic [7:0] CHAR_MINUS   = "-";
   localparam logic [7:0] CHAR_NONE    = 8'h00;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_EOF, KIND_ERROR, KIND_INT, KIND_FLOAT, KIND_NAME,
      KIND_LPAREN, KIND_RPAREN, KIND_LBRACE, KIND_RBRACE, KIND_LBRACKET, KIND_RBRACKET,
      KIND_SEMI, KIND_COMMA, KIND_DOT, KIND_CARET, KIND_AMP, KIND_TILDE, KIND_PERCENT,
      KIND_COLON, KIND_PLUS, KIND_PLUS_EQ, KIND_MINUS, KIND_MINUS_EQ, KIND_ARROW,
      KIND_STAR, KIND_STAR_EQ, KIND_SLASH, KIND_SLASH_EQ, KIND_BANG, KIND_BANG_EQ,
      KIND_ASSIGN, KIND_EQ_EQ, KIND_LESS, KIND_LESS_EQ, KIND_GREATER, KIND_GREATER_EQ
   } token_kind_type;

   typedef enum logic [7:0] {
      MODE_IDLE       = 8'b0000_0001,
      MODE_NUMBER     = 8'b0000_0010,
      MODE_NAME       = 8'b0000_0100,
      MODE_OP         = 8'b0000_1000,
      MODE_LINE       = 8'b0001_0000,
      MODE_BLOCK      = 8'b0010_0000,
      MODE_BLOCK_STAR = 8'b0100_0000,
      MODE_ERRORED    = 8'b1000_0000
   } mode_type;

   typedef logic [INDEX_BITS-1:0] index_type;

   typedef struct packed {
      logic                  last;
      logic [FIELD_BITS-1:0] line_num;
      logic [FIELD_BITS-1:0] end_idx;
      logic [FIELD_BITS-1:0] start_idx;
      token_kind_type        kind;
   } token_type;

   // Outcome of classifying a byte that opens a new token
   typedef struct packed {
      mode_type       mode;
      logic           take_start;
      logic           clear_dot;
      logic [7:0]     pend;
      logic           emit;
      token_kind_type kind;
      logic           line_inc;
   } fresh_type;

   function automatic logic digit_byte(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic ident_byte(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   function automatic logic is_op_char(input logic [7:0] c);
      return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
             (c == "!") || (c == "=") || (c == "<") || (c == ">");
   endfunction

   // KIND_EOF means the byte is no single punctuation
   function automatic token_kind_type punct_kind(input logic [7:0] c);
      token_kind_type k;
      case (c)
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         "[":     k = KIND_LBRACKET;
         "]":     k = KIND_RBRACKET;
         ";":     k = KIND_SEMI;
         ",":     k = KIND_COMMA;
         ".":     k = KIND_DOT;
         "^":     k = KIND_CARET;
         "&":     k = KIND_AMP;
         "~":     k = KIND_TILDE;
         "%":     k = KIND_PERCENT;
         ":":     k = KIND_COLON;
         default: k = KIND_EOF;
      endcase
      return k;
   endfunction

   function automatic token_kind_type op_kind(input logic [7:0] p, input logic dbl);
      token_kind_type k;
      case (p)
         "+":     k = dbl ? KIND_PLUS_EQ  : KIND_PLUS;
         "-":     k = dbl ? KIND_MINUS_EQ : KIND_MINUS;
         "*":     k = dbl ? KIND_STAR_EQ  : KIND_STAR;
         "/":     k = dbl ? KIND_SLASH_EQ : KIND_SLASH;
         "!":     k = dbl ? KIND_BANG_EQ  : KIND_BANG;
         "=":     k = dbl ? KIND_EQ_EQ    : KIND_ASSIGN;
         "<":     k = dbl ? KIND_LESS_EQ  : KIND_LESS;
         default: k = dbl ? KIND_GREATER_EQ : KIND_GREATER;
      endcase
      return k;
   endfunction

   function automatic fresh_type fresh_eval(input logic [7:0] c);
      fresh_type f;
      token_kind_type pk;
      pk = punct_kind(c);
      f = '{mode: MODE_IDLE, take_start: 1'b0, clear_dot: 1'b0, pend: CHAR_NONE,
            emit: 1'b0, kind: KIND_ERROR, line_inc: 1'b0};
      if ((c == CHAR_SPACE) || (c == CHAR_TAB)) begin
         f.mode = MODE_IDLE;
      end else if (c == CHAR_NEWLINE) begin
         f.line_inc = 1'b1;
      end else if (digit_byte(c)) begin
         f.mode       = MODE_NUMBER;
         f.clear_dot  = 1'b1;
         f.take_start = 1'b1;
      end else if (ident_byte(c)) begin
         f.mode       = MODE_NAME;
         f.take_start = 1'b1;
      end else if (is_op_char(c)) begin
         f.mode       = MODE_OP;
         f.pend       = c;
         f.take_start = 1'b1;
      end else if (pk != KIND_EOF) begin
         f.emit = 1'b1;
         f.kind = pk;
      end else begin
         f.emit = 1'b1;
         f.kind = KIND_ERROR;
         f.mode = MODE_ERRORED;
      end
      return f;
   endfunction

endpackage

### hdl/source_tokenizer_top.sv
// Streaming tokenizer: one source byte in, zero to three tokens out.
// Depends on stok_pkg for types, kinds and byte classification.
//
//  Channel   Dir  tdata                                        tlast
//  req_      in   [7:0] source_byte                            end_of_source
//  rsp_      out  [5:0] kind [21:6] start [37:22] end          last_token (EOF)
//                 [53:38] line, [55:54] zero
//
// One byte is taken per cycle: the byte waits in an input register, and the
// lexer state update plus token build run combinationally into an 8-entry token
// queue. A byte moves on only while the queue has room for three tokens, so a
// slow result side stalls the input. Tokens leave the queue head one per cycle
// while rsp_tready is high. Reset is synchronous and clears the lexer state and the queue.
module source_tokenizer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] source_byte
   input  logic        req_tlast,   // end_of_source
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [5:0] token_kind, [21:6] start_index,
                                    // [37:22] end_index, [53:38] line_number
   output logic        rsp_tlast    // last_token
);

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_eos_ff;

   // lexer state
   stok_pkg::mode_type   mode_ff, mode_in;
   logic                 dot_ff, dot_in;
   stok_pkg::index_type  start_ff, start_in;
   stok_pkg::index_type  index_ff, index_in;
   logic [stok_pkg::FIELD_BITS-1:0] line_ff, line_in;
   logic [7:0]           pend_ff, pend_in;

   // token queue
   stok_pkg::token_type  fifo_ff [stok_pkg::FIFO_DEPTH];
   logic [stok_pkg::PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [stok_pkg::PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [stok_pkg::CNT_BITS-1:0] count_ff, count_in;

   stok_pkg::token_type  tok [stok_pkg::MAX_TOKENS];
   logic [1:0]           tok_cnt;
   logic                 fire;
   logic                 pop;

   assign fire       = in_valid_ff &&
                       (count_ff <= stok_pkg::CNT_BITS'(stok_pkg::FIFO_DEPTH -
                                                        stok_pkg::MAX_TOKENS));
   assign req_tready = !in_valid_ff || fire;
   assign in_valid_in = req_tvalid ? 1'b1 : (in_valid_ff && !fire);

   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {2'b00, fifo_ff[rd_ptr_ff].line_num, fifo_ff[rd_ptr_ff].end_idx,
                        fifo_ff[rd_ptr_ff].start_idx, fifo_ff[rd_ptr_ff].kind};
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].last;

   // Lexer step for the byte in the input register
   always_comb begin
      logic [7:0]          c;
      logic                eos;
      stok_pkg::index_type idx, prev, nxt;
      logic                line_inc;
      logic                run_fresh;
      stok_pkg::fresh_type f;
      logic [stok_pkg::FIELD_BITS-1:0] line_after;

      c         = in_byte_ff;
      eos       = in_eos_ff;
      idx       = index_ff;
      prev      = idx - 1'b1;
      nxt       = idx + 1'b1;
      line_inc  = 1'b0;
      run_fresh = 1'b0;
      f         = stok_pkg::fresh_eval(c);
      tok_cnt   = '0;
      for (int i = 0; i < stok_pkg::MAX_TOKENS; i++) begin
         tok[i] = '0;
      end

      mode_in  = mode_ff;
      dot_in   = dot_ff;
      start_in = start_ff;
      pend_in  = pend_ff;

      case (mode_ff)
         stok_pkg::MODE_NUMBER: begin
            if (stok_pkg::digit_byte(c)) begin
               mode_in = mode_ff;
            end else if (c == stok_pkg::CHAR_DOT) begin
               if (dot_ff) begin
                  tok[tok_cnt] = '{last: 1'b0, line_num: line_ff,
                                   end_idx: stok_pkg::FIELD_BITS'(idx),
                                   start_idx: stok_pkg::FIELD_BITS'(idx),
                                   kind: stok_pkg::KIND_ERROR};
                  tok_cnt = tok_cnt + 1'b1;
                  mode_in = stok_pkg::MODE_ERRORED;
               end else begin
                  dot_in = 1'b1;
               end
            end else begin
               tok[tok_cnt] = '{last: 1'b0, line_num: line_ff,
                                end_idx: stok_pkg::FIELD_BITS'(prev),
                                start_idx: stok_pkg::FIELD_BITS'(start_ff),
                                kind: dot_ff ? stok_pkg::KIND_FLOAT : stok_pkg::KIND_INT};
               tok_cnt   = tok_cnt + 1'b1;
               run_fresh = 1'b1;
            end
         end
         stok_pkg::MODE_NAME: begin
            if (!(stok_pkg::ident_byte(c) || stok_pkg::digit_byte(c))) begin
               tok[tok_cnt] = '{last: 1'b0, line_num: line_ff,
                                end_idx: stok_pkg::FIELD_BITS'(prev),
                                start_idx: stok_pkg::FIELD_BITS'(start_ff),
                                kind: stok_pkg::KIND_NAME};
               tok_cnt   = tok_cnt + 1'b1;
               run_fresh = 1'b1;
            end
         end
         stok_pkg::MODE_OP: begin
            if ((pend_ff == stok_pkg::CHAR_SLASH) && (c == stok_pkg::CHAR_SLASH)) begin
               mode_in = stok_pkg::MODE_LINE;
               pend_in = stok_pkg::CHAR_NONE;
            end else if ((pend_ff == stok_pkg::CHAR_SLASH) && (c == stok_pkg::CHAR_STAR)) begin
               mode_in = stok_pkg::MODE_BLOCK;
               pend_in = stok_pkg::CHAR_NONE;
            end else if ((pend_ff == stok_pkg::CHAR_MINUS) &&
                         (c == stok_pkg::CHAR_GREATER)) begin
               tok[tok_cnt] = '{last: 1'b0, line_num: line_ff,
                                end_idx: stok_pkg::FIELD_BITS'(idx),
                                start_idx: stok_pkg::FIELD_BITS'(start_ff),
                                kind: stok_pkg::KIND_ARROW};
               tok_cnt = tok_cnt + 1'b1;
               mode_in = stok_pkg::MODE_IDLE;
               pend_in = stok_pkg::CHAR_NONE;
            end else if (c == stok_pkg::CHAR_EQUAL) begin
               tok[tok_cnt] = '{last: 1'b0, line_num: line_ff,
                                end_idx: stok_pkg::FIELD_BITS'(idx),
                                start_idx: stok_pkg::FIELD_BITS'(start_ff),
                                kind: stok_pkg::op_kind(pend_ff, 1'b1)};
               tok_cnt = tok_cnt + 1'b1;
               mode_in = stok_pkg::MODE_IDLE;
               pend_in = stok_pkg::CHAR_NONE;
            end else begin
               tok[tok_cnt] = '{last: 1'b0, line_num: line_ff,
                                end_idx: stok_pkg::FIELD_BITS'(start_ff),
                                start_idx: stok_pkg::FIELD_BITS'(start_ff),
                                kind: stok_pkg::op_kind(pend_ff, 1'b0)};
               tok_cnt   = tok_cnt + 1'b1;
               run_fresh = 1'b1;
            end
         end
         stok_pkg::MODE_LINE: begin
            if (c == stok_pkg::CHAR_NEWLINE) begin
               line_inc = 1'b1;
               mode_in  = stok_pkg::MODE_IDLE;
            end
         end
         stok_pkg::MODE_BLOCK: begin
            if (c == stok_pkg::CHAR_NEWLINE) begin
               line_inc = 1'b1;
            end else if (c == stok_pkg::CHAR_STAR) begin
               mode_in = stok_pkg::MODE_BLOCK_STAR;
            end
         end
         stok_pkg::MODE_BLOCK_STAR: begin
            if (c == stok_pkg::CHAR_SLASH) begin
               mode_in = stok_pkg::MODE_IDLE;
            end else if (c != stok_pkg::CHAR_STAR) begin
               line_inc = (c == stok_pkg::CHAR_NEWLINE);
               mode_in  = stok_pkg::MODE_BLOCK;
            end
         end
         stok_pkg::MODE_ERRORED: begin
            mode_in = mode_ff;
         end
         default: begin
            run_fresh = 1'b1;
         end
      endcase

      // open a new token, or skip, on a byte seen in idle mode or on the byte that ended the previous one
      if (run_fresh) begin
         mode_in = f.mode;
         pend_in = f.pend;
         if (f.take_start) begin
            start_in = idx;
         end
         if (f.clear_dot) begin
            dot_in = 1'b0;
         end
         if (f.emit) begin
            tok[tok_cnt] = '{last: 1'b0, line_num: line_ff,
                             end_idx: stok_pkg::FIELD_BITS'(idx),
                             start_idx: stok_pkg::FIELD_BITS'(idx),
                             kind: f.kind};
            tok_cnt = tok_cnt + 1'b1;
         end
         line_inc = f.line_inc;
      end

      line_after = (line_inc && (line_ff != stok_pkg::LINE_MAX)) ? line_ff + 1'b1 : line_ff;
      line_in    = line_after;
      index_in   = nxt;

      if (eos) begin
         // flush an open token, then close the source
         case (mode_in)
            stok_pkg::MODE_NUMBER: begin
               tok[tok_cnt] = '{last: 1'b0, line_num: line_after,
                                end_idx: stok_pkg::FIELD_BITS'(idx),
                                start_idx: stok_pkg::FIELD_BITS'(start_in),
                                kind: dot_in ? stok_pkg::KIND_FLOAT : stok_pkg::KIND_INT};
               tok_cnt = tok_cnt + 1'b1;
            end
            stok_pkg::MODE_NAME: begin
               tok[tok_cnt] = '{last: 1'b0, line_num: line_after,
                                end_idx: stok_pkg::FIELD_BITS'(idx),
                                start_idx: stok_pkg::FIELD_BITS'(start_in),
                                kind: stok_pkg::KIND_NAME};
               tok_cnt = tok_cnt + 1'b1;
            end
            stok_pkg::MODE_OP: begin
               tok[tok_cnt] = '{last: 1'b0, line_num: line_after,
                                end_idx: stok_pkg::FIELD_BITS'(start_in),
                                start_idx: stok_pkg::FIELD_BITS'(start_in),
                                kind: stok_pkg::op_kind(pend_in, 1'b0)};
               tok_cnt = tok_cnt + 1'b1;
            end
            default: begin
               tok_cnt = tok_cnt;
            end
         endcase
         tok[tok_cnt] = '{last: 1'b1, line_num: line_after,
                          end_idx: stok_pkg::FIELD_BITS'(nxt),
                          start_idx: stok_pkg::FIELD_BITS'(nxt),
                          kind: stok_pkg::KIND_EOF};
         tok_cnt  = tok_cnt + 1'b1;
         mode_in  = stok_pkg::MODE_IDLE;
         dot_in   = 1'b0;
         start_in = '0;
         index_in = '0;
         line_in  = '0;
         pend_in  = stok_pkg::CHAR_NONE;
      end
   end

   assign wr_ptr_in = wr_ptr_ff + (fire ? stok_pkg::PTR_BITS'(tok_cnt) : '0);
   assign rd_ptr_in = rd_ptr_ff + (pop ? 1'b1 : 1'b0);
   assign count_in  = count_ff + (fire ? stok_pkg::CNT_BITS'(tok_cnt) : '0) -
                      (pop ? 1'b1 : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= stok_pkg::MODE_IDLE;
         dot_ff      <= 1'b0;
         start_ff    <= '0;
         index_ff    <= '0;
         line_ff     <= '0;
         pend_ff     <= stok_pkg::CHAR_NONE;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            mode_ff  <= mode_in;
            dot_ff   <= dot_in;
            start_ff <= start_in;
            index_ff <= index_in;
            line_ff  <= line_in;
            pend_ff  <= pend_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eos_ff  <= req_tlast;
      end
      if (fire) begin
         for (int i = 0; i < stok_pkg::MAX_TOKENS; i++) begin
            if (2'(i) < tok_cnt) begin
               fifo_ff[wr_ptr_ff + stok_pkg::PTR_BITS'(i)] <= tok[i];
            end
         end
      end
   end

endmodule

### hdl/stok_checker.sv
// Port-level checks on the tokenizer result stream, bound to source_tokenizer_top.
// Depends on stok_pkg and the assertion macros in source_tokenizer_top_defines.svh.
`include "source_tokenizer_top_defines.svh"

module stok_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic [5:0]  kind;
   logic        eof_word;
   logic        kind_ok;
   logic        eof_pos_ok;

   assign kind       = rsp_tdata[5:0];
   assign eof_word   = (kind == stok_pkg::KIND_EOF);
   assign kind_ok    = (kind <= stok_pkg::KIND_GREATER_EQ) && (rsp_tdata[55:54] == 2'b00);
   assign eof_pos_ok = (rsp_tdata[21:6] == rsp_tdata[37:22]);

   // hold a stalled input word
   `STOK_ASSERT_NEXT(a_req_hold, clock, reset, req_tvalid && !req_tready,
      req_tvalid && $stable(req_tdata) && $stable(req_tlast), "stalled input word changed")

   // hold a stalled word
   `STOK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled word changed")

   `STOK_ASSERT_NOW(a_last_is_eof, clock, reset, rsp_tvalid && rsp_tlast,
      eof_word && eof_pos_ok, "last word is not an EOF token")

   `STOK_ASSERT_NOW(a_eof_is_last, clock, reset, rsp_tvalid && eof_word,
      rsp_tlast, "EOF token without last flag")

   `STOK_ASSERT_NOW(a_kind_range, clock, reset, rsp_tvalid,
      kind_ok, "token kind out of range")

endmodule

bind source_tokenizer_top stok_checker u_stok_checker (.*);
